// ===== rtl/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg
// shared types for the merge sort engine: sequencer states and the control
// bundle that the sequencer hands to the datapath
// ----------------------------------------------------------------------------
package mse_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_READ,
        S_MERGE,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic in_we;
        logic mrg_we;
        logic src_sel;
        logic out_valid;
        logic out_last;
        logic overflow;
        logic a_live;
        logic b_live;
    } t_seq_ctl;

endpackage

// ===== rtl/merge_sort_engine_core.sv =====
// ----------------------------------------------------------------------------
// merge_sort_engine_core
// collects signed values until a word with tlast, sorts them ascending by a
// bottom-up merge, then streams them out with tlast on the final one
// ----------------------------------------------------------------------------
// Timing: one input word is taken per cycle while collecting. After the
// closing word the set of n values (n <= MAX_ELEMENTS) is sorted in
// ceil(log2(n)) passes; in a pass each element is first read from ram, then
// compared and written through the one shared comparator, and a setup state
// opens every run pair and closes every pass. Each result is then read from
// ram and presented until the receiver takes it. A full set of 64 takes six
// passes. Input is not taken while a set is being sorted or emitted. Words
// past capacity are dropped and tuser (overflow) is high on every result of
// that set. Equal values leave in their input order.
module merge_sort_engine_core #(
    parameter int MAX_ELEMENTS = 64,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic        i_s_tlast,   // last_in
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] sorted_value
    output logic        o_m_tlast,   // last_out
    output logic        o_m_tuser    // [0] overflow
);

    localparam int AW = $clog2(MAX_ELEMENTS);

    mse_pkg::t_seq_ctl ctl;
    logic [AW-1:0]          waddr;
    logic [AW-1:0]          raddr_a;
    logic [AW-1:0]          raddr_b;
    logic                   take_a;
    logic [VALUE_WIDTH+31:0] in_ext;
    logic [VALUE_WIDTH+31:0] out_ext;
    logic [VALUE_WIDTH-1:0] in_val;
    logic [VALUE_WIDTH-1:0] mrg_data;
    logic [VALUE_WIDTH-1:0] ram0_a, ram0_b, ram1_a, ram1_b;
    logic [VALUE_WIDTH-1:0] src_a, src_b;
    logic                   ram0_we, ram1_we;
    logic [VALUE_WIDTH-1:0] ram0_wdata;

    // keep the low VALUE_WIDTH bits of the input, zero filled when wider
    assign in_ext  = {(VALUE_WIDTH)'(0), i_s_tdata};
    assign in_val  = in_ext[VALUE_WIDTH-1:0];

    mse_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_in_last   (i_s_tlast),
        .i_out_ready (i_m_tready),
        .i_take_a    (take_a),
        .o_ctl       (ctl),
        .o_waddr     (waddr),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b)
    );

    // passes ping-pong between the two rams, ram0 is loaded first
    assign ram0_we    = ctl.in_we || (ctl.mrg_we && ctl.src_sel);
    assign ram1_we    = ctl.mrg_we && !ctl.src_sel;
    assign ram0_wdata = ctl.in_we ? in_val : mrg_data;

    mse_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram0 (
        .i_clk     (i_clk),
        .i_we      (ram0_we),
        .i_waddr   (waddr),
        .i_wdata   (ram0_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (ram0_a),
        .o_rdata_b (ram0_b)
    );

    mse_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram1 (
        .i_clk     (i_clk),
        .i_we      (ram1_we),
        .i_waddr   (waddr),
        .i_wdata   (mrg_data),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (ram1_a),
        .o_rdata_b (ram1_b)
    );

    assign src_a = ctl.src_sel ? ram1_a : ram0_a;
    assign src_b = ctl.src_sel ? ram1_b : ram0_b;

    mse_merge #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_merge (
        .i_a_data (src_a),
        .i_b_data (src_b),
        .i_a_live (ctl.a_live),
        .i_b_live (ctl.b_live),
        .o_take_a (take_a),
        .o_data   (mrg_data)
    );

    assign out_ext    = {32'(0), src_a};
    assign o_s_tready = ctl.in_ready;
    assign o_m_tvalid = ctl.out_valid;
    assign o_m_tdata  = out_ext[31:0];
    assign o_m_tlast  = ctl.out_last;
    assign o_m_tuser  = ctl.overflow;

endmodule

// ===== rtl/mse_ram.sv =====
// ----------------------------------------------------------------------------
// mse_ram
// generic ram: one write port, two read ports, registered read data
// ----------------------------------------------------------------------------
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== rtl/mse_merge.sv =====
// ----------------------------------------------------------------------------
// mse_merge
// shared merge comparator: picks the head of the left or right run
// ----------------------------------------------------------------------------
module mse_merge #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic [VALUE_WIDTH-1:0] i_a_data,
    input  logic [VALUE_WIDTH-1:0] i_b_data,
    input  logic                   i_a_live,
    input  logic                   i_b_live,
    output logic                   o_take_a,
    output logic [VALUE_WIDTH-1:0] o_data
);

    logic a_le_b;

    // left run wins ties so equal values keep input order
    assign a_le_b   = $signed(i_a_data) <= $signed(i_b_data);
    assign o_take_a = i_a_live && (!i_b_live || a_le_b);
    assign o_data   = o_take_a ? i_a_data : i_b_data;

endmodule

// ===== rtl/mse_seq.sv =====
// ----------------------------------------------------------------------------
// mse_seq
// sequencer: load counting, bottom-up merge passes, emit counting
// ----------------------------------------------------------------------------
module mse_seq #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_last,
    input  logic                            i_out_ready,
    input  logic                            i_take_a,
    output mse_pkg::t_seq_ctl               o_ctl,
    output logic [$clog2(MAX_ELEMENTS)-1:0] o_waddr,
    output logic [$clog2(MAX_ELEMENTS)-1:0] o_raddr_a,
    output logic [$clog2(MAX_ELEMENTS)-1:0] o_raddr_b
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1) + 1;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    mse_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic          r_drop, n_drop;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_width, n_width;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_a, n_a;
    logic [CW-1:0] r_b, n_b;
    logic [CW-1:0] r_k, n_k;
    logic          r_src, n_src;

    logic          has_room;
    logic [CW-1:0] close_cnt;
    logic [CW-1:0] sum_mid;
    logic [CW-1:0] sum_hi;
    logic [CW-1:0] width_x2;
    logic          pass_done;
    logic          run_done;
    logic          emit_last;

    assign has_room  = r_fill < MAX_C;
    assign close_cnt = has_room ? r_fill + ONE_C : r_fill;
    assign sum_mid   = r_lo + r_width;
    assign width_x2  = r_width << 1;
    assign sum_hi    = r_lo + width_x2;
    assign pass_done = r_lo >= r_n;
    assign run_done  = (r_k + ONE_C) == r_hi;
    assign emit_last = (r_k + ONE_C) == r_n;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mse_pkg::S_IDLE: begin
                if (i_in_valid && i_in_last) begin
                    n_state = (close_cnt >= CW'(2)) ? mse_pkg::S_SETUP : mse_pkg::S_EMIT_RD;
                end
            end
            mse_pkg::S_SETUP: begin
                if (pass_done) begin
                    n_state = (width_x2 >= r_n) ? mse_pkg::S_EMIT_RD : mse_pkg::S_SETUP;
                end else begin
                    n_state = mse_pkg::S_READ;
                end
            end
            mse_pkg::S_READ:  n_state = mse_pkg::S_MERGE;
            mse_pkg::S_MERGE: n_state = run_done ? mse_pkg::S_SETUP : mse_pkg::S_READ;
            mse_pkg::S_EMIT_RD: n_state = mse_pkg::S_EMIT;
            mse_pkg::S_EMIT: begin
                if (i_out_ready) begin
                    n_state = emit_last ? mse_pkg::S_IDLE : mse_pkg::S_EMIT_RD;
                end
            end
            default: n_state = mse_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctl           = '0;
        o_ctl.src_sel   = r_src;
        o_ctl.overflow  = r_drop;
        o_ctl.out_last  = emit_last;
        o_ctl.a_live    = r_a < r_mid;
        o_ctl.b_live    = r_b < r_hi;
        o_waddr         = r_k[AW-1:0];
        o_raddr_a       = r_a[AW-1:0];
        o_raddr_b       = r_b[AW-1:0];
        unique case (r_state)
            mse_pkg::S_IDLE: begin
                o_ctl.in_ready = 1'b1;
                o_ctl.in_we    = i_in_valid && has_room;
                o_waddr        = r_fill[AW-1:0];
            end
            mse_pkg::S_MERGE: o_ctl.mrg_we = 1'b1;
            mse_pkg::S_EMIT_RD, mse_pkg::S_EMIT: begin
                o_raddr_a       = r_k[AW-1:0];
                o_ctl.out_valid = r_state == mse_pkg::S_EMIT;
            end
            default: ;
        endcase
    end

    // counters and run bounds
    always_comb begin
        n_fill  = r_fill;
        n_drop  = r_drop;
        n_n     = r_n;
        n_width = r_width;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_a     = r_a;
        n_b     = r_b;
        n_k     = r_k;
        n_src   = r_src;
        unique case (r_state)
            mse_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (has_room) begin
                        n_fill = r_fill + ONE_C;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_in_last) begin
                        n_n     = close_cnt;
                        n_width = ONE_C;
                        n_lo    = '0;
                        n_src   = 1'b0;
                        n_k     = '0;
                    end
                end
            end
            mse_pkg::S_SETUP: begin
                if (pass_done) begin
                    n_src   = ~r_src;
                    n_width = width_x2;
                    n_lo    = '0;
                    n_k     = '0;
                end else begin
                    n_mid = (sum_mid > r_n) ? r_n : sum_mid;
                    n_hi  = (sum_hi > r_n) ? r_n : sum_hi;
                    n_a   = r_lo;
                    n_b   = (sum_mid > r_n) ? r_n : sum_mid;
                    n_k   = r_lo;
                end
            end
            mse_pkg::S_MERGE: begin
                n_k = r_k + ONE_C;
                if (i_take_a) begin
                    n_a = r_a + ONE_C;
                end else begin
                    n_b = r_b + ONE_C;
                end
                if (run_done) begin
                    n_lo = sum_hi;
                end
            end
            mse_pkg::S_EMIT: begin
                if (i_out_ready) begin
                    n_k = r_k + ONE_C;
                    if (emit_last) begin
                        n_fill = '0;
                        n_drop = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mse_pkg::S_IDLE;
            r_fill  <= '0;
            r_drop  <= 1'b0;
            r_src   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_drop  <= n_drop;
            r_src   <= n_src;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_width <= n_width;
        r_lo    <= n_lo;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_a     <= n_a;
        r_b     <= n_b;
        r_k     <= n_k;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= MAX_C)
        else $error("fill count beyond capacity");

    a_merge_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mse_pkg::S_MERGE |-> (o_ctl.a_live || o_ctl.b_live))
        else $error("merge step with both runs exhausted");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mse_pkg::S_EMIT |-> (r_k < r_n && r_n <= MAX_C))
        else $error("emit index outside the stored set");

    a_set_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mse_pkg::S_EMIT && i_out_ready && emit_last)
        |=> (r_fill == '0 && !r_drop && r_state == mse_pkg::S_IDLE))
        else $error("set state not cleared after final word");

    a_pass_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mse_pkg::S_SETUP |-> r_width < r_n)
        else $error("merge pass started with run width not below set size");

endmodule

// ===== dv/tb_merge_sort_engine_core.sv =====
// ----------------------------------------------------------------------------
// tb_merge_sort_engine_core
// streams sets of signed words into the sort engine and checks every sorted
// word, its tlast and its overflow flag against a stable ascending sort of
// the stored set; the sender runs in bursts, the receiver stalls on its own
// pattern and once holds off long enough to back the engine up
// ----------------------------------------------------------------------------
module tb_merge_sort_engine_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_CAPACITY  = 64;
    localparam int WORD_TARGET   = 270;
    localparam int STALL_LIMIT   = 20000;
    localparam int HOLD_OFF_LEN  = 500;
    localparam int HOLD_OFF_AT   = 40;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        overflow;
    } t_sorted_word;

    class sort_scoreboard #(int CAPACITY = 64);
        logic signed [31:0] set_words[$];
        bit                 set_dropped;
        t_sorted_word       expected[$];
        int                 errors;
        int                 results_checked;
        int                 sets_closed;
        int                 overflow_sets;

        // store the word like the engine does; on the closing word queue the
        // set in stable ascending order
        function void note_input(logic [31:0] value, logic last);
            logic signed [31:0] ordered[$];
            logic signed [31:0] key;
            t_sorted_word       word;
            int                 j;
            if (set_words.size() < CAPACITY)
                set_words.push_back(value);
            else
                set_dropped = 1'b1;
            if (!last)
                return;
            ordered = set_words;
            for (int i = 1; i < ordered.size(); i++) begin
                key = ordered[i];
                j = i - 1;
                // strict compare keeps equal values in arrival order
                while (j >= 0 && ordered[j] > key) begin
                    ordered[j + 1] = ordered[j];
                    j--;
                end
                ordered[j + 1] = key;
            end
            for (int i = 0; i < ordered.size(); i++) begin
                word.value    = ordered[i];
                word.last     = (i == ordered.size() - 1);
                word.overflow = set_dropped;
                expected.push_back(word);
            end
            sets_closed++;
            if (set_dropped)
                overflow_sets++;
            set_words.delete();
            set_dropped = 1'b0;
        endfunction

        function void check_result(logic [31:0] data, logic last, logic user);
            t_sorted_word want;
            results_checked++;
            if (expected.size() == 0) begin
                $error("unexpected word: sorted_value %h last_out %b overflow %b",
                       data, last, user);
                errors++;
                return;
            end
            want = expected.pop_front();
            if (data !== want.value) begin
                $error("sorted_value: expected %h actual %h", want.value, data);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_out: expected %b actual %b", want.last, last);
                errors++;
            end
            if (user !== want.overflow) begin
                $error("overflow: expected %b actual %b", want.overflow, user);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;   // [31:0] value
    logic        i_s_tlast;   // last_in
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;   // [31:0] sorted_value
    logic        o_m_tlast;   // last_out
    logic        o_m_tuser;   // [0] overflow

    sort_scoreboard #(SET_CAPACITY) sb;

    int words_sent;
    int burst_left;
    bit gapless;
    bit held_off;
    int quiet_cycles;

    merge_sort_engine_core #(
        .MAX_ELEMENTS(SET_CAPACITY),
        .VALUE_WIDTH (32)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tlast (i_s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast),
        .o_m_tuser (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // extremes, a narrow band for duplicates, and full-range words
    function automatic logic [31:0] pick_value();
        int mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0: begin
                return 32'h8000_0000;
            end
            1: begin
                return 32'h7fff_ffff;
            end
            2: begin
                return 32'h0000_0000;
            end
            3: begin
                return 32'hffff_ffff;
            end
            4, 5: begin
                return 32'($urandom_range(0, 15)) - 32'd8;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic send_word(input logic [31:0] value, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = gapless ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
                i_s_tdata  <= $urandom;
                i_s_tlast  <= 1'($urandom_range(0, 1));
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(value, last);
        words_sent++;
    endtask

    task automatic send_set(input int count);
        gapless = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++)
            send_word(pick_value(), i == count - 1);
    endtask

    // receiver: phases of steady, random and patterned stalls, plus one long
    // hold-off so the engine fills and stops taking input
    initial begin
        int mode;
        int phase_left;
        int tick;
        i_m_tready = 1'b0;
        phase_left = 0;
        mode = 0;
        tick = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held_off && sb.results_checked >= HOLD_OFF_AT) begin
                held_off = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(negedge i_clk);
            end
            if (phase_left == 0) begin
                mode = $urandom_range(0, 3);
                phase_left = $urandom_range(16, 96);
            end
            phase_left--;
            tick++;
            case (mode)
                0: begin
                    i_m_tready <= 1'b1;
                end
                1: begin
                    i_m_tready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    i_m_tready <= (tick % 4 != 0);
                end
                default: begin
                    i_m_tready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata, o_m_tlast, o_m_tuser);
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int set_idx;
        sb = new();
        words_sent = 0;
        burst_left = 0;
        gapless = 1'b0;
        set_idx = 0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single-word sets at the extremes
        send_word(32'h8000_0000, 1'b1);
        send_word(32'h7fff_ffff, 1'b1);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'hffff_ffff, 1'b1);
        // mixed signs
        send_word(32'h7fff_ffff, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'hffff_ffff, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        // duplicates
        send_word(32'd5, 1'b0);
        send_word(32'd5, 1'b0);
        send_word(32'hffff_fffb, 1'b0);
        send_word(32'd5, 1'b1);
        // reverse order
        send_word(32'd3, 1'b0);
        send_word(32'd2, 1'b0);
        send_word(32'd1, 1'b0);
        send_word(32'd0, 1'b0);
        send_word(32'hffff_ffff, 1'b1);
        // already sorted, neighbors of the extremes
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h8000_0001, 1'b0);
        send_word(32'h7fff_fffe, 1'b0);
        send_word(32'h7fff_ffff, 1'b1);

        // mostly short sets, one exactly full and two that run past capacity
        while (words_sent < WORD_TARGET) begin
            case (set_idx)
                2: begin
                    send_set(SET_CAPACITY);
                end
                5: begin
                    send_set(SET_CAPACITY + $urandom_range(1, 6));
                end
                9: begin
                    send_set(SET_CAPACITY + 1);
                end
                default: begin
                    if ($urandom_range(0, 4) == 0)
                        send_set($urandom_range(11, 32));
                    else
                        send_set($urandom_range(1, 10));
                end
            endcase
            set_idx++;
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.expected.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("covered %0d sets (%0d with dropped words) from %0d input words",
                 sb.sets_closed, sb.overflow_sets, words_sent);
        $display("checked %0d sorted words, %0d field errors",
                 sb.results_checked, sb.errors);
        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mse_pkg.sv
rtl/mse_ram.sv
rtl/mse_merge.sv
rtl/mse_seq.sv
rtl/merge_sort_engine_core.sv
dv/tb_merge_sort_engine_core.sv
